### src/pls_pkg.sv
// shared types and constants for the positional list block
// no dependencies; imported by the cell, result and top level modules
`default_nettype none

package pls_pkg;

  // list depth and derived widths
  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // fixed field widths of the stream beats
  localparam int CMD_W  = 2;
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int STAT_W = 3;
  localparam int MIDX_W = 5;
  localparam int LEN_W  = 6;

  // width that holds both a position and a count for compares
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // packed beat widths, rounded up to whole bytes
  localparam int S_BITS    = CMD_W + POS_W + DATA_W;
  localparam int S_TDATA_W = ((S_BITS + 7) / 8) * 8;
  localparam int M_BITS    = STAT_W + 1 + MIDX_W + LEN_W;
  localparam int M_TDATA_W = ((M_BITS + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // what one cell does at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_SHIFT_UP   = 2'd2,
    CELL_SHIFT_DOWN = 2'd3
  } cell_op_e;

  // command outcome handed from the list stage to the result stage
  typedef struct packed {
    status_e             status;
    logic                search;
    logic [LEN_W-1:0]    length;
  } exec_t;

  // one result beat
  typedef struct packed {
    status_e             status;
    logic                found;
    logic [MIDX_W-1:0]   match_index;
    logic [LEN_W-1:0]    length;
  } res_t;

endpackage

`default_nettype wire

### src/pls_cell.sv
// one storage cell of the list chain: holds an entry and compares it
// depends on pls_pkg
`default_nettype none

module pls_cell (
  input  wire logic                          clk_i,
  input  wire pls_pkg::cell_op_e             op_i,
  input  wire logic [pls_pkg::DATA_W-1:0]    value_i,
  input  wire logic [pls_pkg::DATA_W-1:0]    left_i,
  input  wire logic [pls_pkg::DATA_W-1:0]    right_i,
  output logic      [pls_pkg::DATA_W-1:0]    data_o,
  output logic                               match_o
);
  import pls_pkg::*;

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  // pick the next entry from the neighbors or the new value
  always_comb begin
    case (op_i)
      CELL_HOLD:       data_d = data_q;
      CELL_LOAD:       data_d = value_i;
      CELL_SHIFT_UP:   data_d = left_i;
      CELL_SHIFT_DOWN: data_d = right_i;
      default:         data_d = data_q;
    endcase
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == value_i);

endmodule

`default_nettype wire

### src/pls_result.sv
// result stage: first-match encoding and the output register
// depends on pls_pkg
`default_nettype none

module pls_result (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire pls_pkg::exec_t                in_exec_i,
  input  wire logic [pls_pkg::CAPACITY-1:0]  in_match_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output pls_pkg::res_t                      out_res_o
);
  import pls_pkg::*;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  res_t             res_d;
  res_t             res_q;
  logic             valid_q;
  logic             valid_d;
  logic             load;

  // lowest matching cell wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = CAPACITY - 1; j >= 0; j--) begin
      if (in_match_i[j]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(j);
      end
    end
  end

  // build the result beat
  always_comb begin
    res_d.status      = in_exec_i.status;
    res_d.found       = 1'b0;
    res_d.match_index = '0;
    res_d.length      = in_exec_i.length;
    if (in_exec_i.search) begin
      if (hit) begin
        res_d.status      = ST_OK;
        res_d.found       = 1'b1;
        res_d.match_index = MIDX_W'(hit_idx);
      end else begin
        res_d.status = ST_NOTFOUND;
      end
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

`default_nettype wire

### src/positional_list_insert_delete_search.sv
// positional list: chain of CAPACITY cells, one beat in, one beat out per command
// the beat is registered in the list stage (cell update), then the result stage (match encode)
// throughput: 1 command per cycle unless results stall; cells shift or compare in the same edge
// ready passes back through both stages, so a stalled result holds two beats inside
// reset: rst_ni clears the count and the valid flags; cell entries are left as is
// depends on pls_pkg, pls_cell, pls_result
`default_nettype none

module positional_list_insert_delete_search (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // cmd [1:0], position [7:2], value [39:8]
  input  wire logic [pls_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // status [2:0], found [3], match_index [8:4], length [14:9], zero [15]
  output logic      [pls_pkg::M_TDATA_W-1:0]    m_axis_tdata_o
);
  import pls_pkg::*;

  // input beat fields
  logic [CMD_W-1:0]  in_cmd;
  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_value;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              s_fire;

  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;
  logic              ins_ok;
  logic              del_ok;
  logic              is_full;
  logic              is_empty;
  exec_t             exec_d;
  exec_t             exec_q;
  logic              exec_valid_q;
  logic              exec_valid_d;
  logic [CAPACITY-1:0] match_d;
  logic [CAPACITY-1:0] match_q;
  logic              res_ready;
  logic              res_valid;
  res_t              res;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  cell_op_e          cell_op [CAPACITY];

  assign in_cmd   = s_axis_tdata_i[CMD_W-1:0];
  assign in_pos   = s_axis_tdata_i[CMD_W+POS_W-1:CMD_W];
  assign in_value = s_axis_tdata_i[CMD_W+POS_W+DATA_W-1:CMD_W+POS_W];
  assign pos_ext  = CMP_W'(in_pos);
  assign cnt_ext  = CMP_W'(count_q);

  assign s_axis_tready_o = !exec_valid_q || res_ready;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // command checks against the current count
  assign is_full  = (count_q == CNT_W'(CAPACITY));
  assign is_empty = (count_q == '0);

  always_comb begin
    ins_ok        = 1'b0;
    del_ok        = 1'b0;
    exec_d.status = ST_OK;
    exec_d.search = 1'b0;
    case (in_cmd)
      CMD_INSERT: begin
        if (is_full) begin
          exec_d.status = ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          exec_d.status = ST_BADPOS;
        end else begin
          ins_ok = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (is_empty) begin
          exec_d.status = ST_EMPTY;
        end else if (pos_ext == '0 || pos_ext > cnt_ext) begin
          exec_d.status = ST_BADPOS;
        end else begin
          del_ok = 1'b1;
        end
      end
      CMD_SEARCH: begin
        if (is_empty) begin
          exec_d.status = ST_EMPTY;
        end else begin
          exec_d.search = 1'b1;
        end
      end
      default: begin
        exec_d.status = ST_OK;
      end
    endcase

    // new count after the command
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + CNT_W'(1);
    end else if (del_ok) begin
      count_d = count_q - CNT_W'(1);
    end
    exec_d.length = LEN_W'(count_d);
  end

  // cell chain: per-cell op, neighbor wiring, masked compare
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;

    if (i == 0) begin : g_first
      assign left = in_value;
    end else begin : g_mid_l
      assign left = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid_r
      assign right = cell_data[i+1];
    end

    always_comb begin
      cell_op[i] = CELL_HOLD;
      if (s_fire && ins_ok) begin
        if (CMP_W'(i) == pos_ext) begin
          cell_op[i] = CELL_LOAD;
        end else if (CMP_W'(i) > pos_ext) begin
          cell_op[i] = CELL_SHIFT_UP;
        end
      end else if (s_fire && del_ok) begin
        if (CMP_W'(i + 1) >= pos_ext) begin
          cell_op[i] = CELL_SHIFT_DOWN;
        end
      end
    end

    pls_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[i]),
      .value_i (in_value),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .match_o (cell_match[i])
    );

    // only entries below the count take part in a search
    assign match_d[i] = cell_match[i] && (CMP_W'(i) < cnt_ext);
  end

  always_comb begin
    if (s_fire) begin
      exec_valid_d = 1'b1;
    end else if (res_ready) begin
      exec_valid_d = 1'b0;
    end else begin
      exec_valid_d = exec_valid_q;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      exec_valid_q <= 1'b0;
    end else begin
      exec_valid_q <= exec_valid_d;
      if (s_fire) begin
        count_q <= count_d;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      exec_q  <= exec_d;
      match_q <= match_d;
    end
  end

  pls_result u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (exec_valid_q),
    .in_ready_o  (res_ready),
    .in_exec_i   (exec_q),
    .in_match_i  (match_q),
    .out_valid_o (res_valid),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  // pack the result beat
  assign m_axis_tvalid_o = res_valid;
  assign m_axis_tdata_o  = M_TDATA_W'({res.length, res.match_index, res.found, res.status});

  // count never goes beyond the list depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // a rejected insert on a full list leaves the count alone
  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_cmd == CMD_INSERT && is_full) |=> (count_q == $past(count_q)))
    else $error("count changed on a full list insert");

  // a stalled command beat is not dropped
  a_exec_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_valid_q && !res_ready) |=> exec_valid_q)
    else $error("command beat lost while result stage stalled");

  // a found flag only comes with an ok status
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.found) |-> (res.status == ST_OK))
    else $error("found set with a failing status");

endmodule

`default_nettype wire

### tb/sv/pls_checker.sv
`timescale 1ns / 1ps
// result checker for the positional list block: tracks the list from the command
// beats, predicts every result beat and compares it field by field
// depends on pls_pkg; instantiated by tb_top beside the block
module pls_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid_i,
  input  wire logic                           s_axis_tready_i,
  // cmd [1:0], position [7:2], value [39:8]
  input  wire logic [pls_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                           m_axis_tvalid_i,
  input  wire logic                           m_axis_tready_i,
  // status [2:0], found [3], match_index [8:4], length [14:9], zero [15]
  input  wire logic [pls_pkg::M_TDATA_W-1:0]  m_axis_tdata_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  checked_o,
  output int                                  peak_len_o
);
  import pls_pkg::*;

  // mirror of the list contents, head at index 0
  logic [DATA_W-1:0] list_q[$];
  // predicted result beats, oldest first
  res_t              outcome_q[$];

  int fail_count = 0;
  int pending    = 0;
  int checked    = 0;
  int peak_len   = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;
  assign checked_o    = checked;
  assign peak_len_o   = peak_len;

  // one line per mismatch, counted
  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    fail_count++;
    $display("[%0t] result beat %0d: %s mismatch, expected %0d, got %0d",
             $realtime, checked, what, want, got);
  endtask

  // apply one command to the mirrored list and return the beat it yields
  function automatic res_t apply_command(input logic [CMD_W-1:0]  op,
                                         input logic [POS_W-1:0]  slot,
                                         input logic [DATA_W-1:0] val);
    res_t r;
    int   cnt;
    r.status      = ST_OK;
    r.found       = 1'b0;
    r.match_index = '0;
    cnt           = list_q.size();
    case (op)
      CMD_INSERT: begin
        // fullness wins over a bad slot
        if (cnt >= CAPACITY) r.status = ST_FULL;
        else if (int'(slot) > cnt) r.status = ST_BADPOS;
        else list_q.insert(int'(slot), val);
      end
      CMD_DELETE: begin
        if (cnt == 0) r.status = ST_EMPTY;
        else if (slot == '0 || int'(slot) > cnt) r.status = ST_BADPOS;
        else list_q.delete(int'(slot) - 1);
      end
      CMD_SEARCH: begin
        if (cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          // first match from the head wins
          for (int i = 0; i < cnt; i++) begin
            if (list_q[i] == val) begin
              r.status      = ST_OK;
              r.found       = 1'b1;
              r.match_index = MIDX_W'(i);
              break;
            end
          end
        end
      end
      default: ; // unused code leaves the list alone
    endcase
    r.length = LEN_W'(list_q.size());
    return r;
  endfunction

  // compare one result beat with the oldest prediction
  task automatic check_result(input logic [M_TDATA_W-1:0] beat);
    res_t want;
    if (outcome_q.size() == 0) begin
      report_mismatch("unexpected beat", 0, beat);
    end else begin
      want = outcome_q.pop_front();
      checked++;
      if (beat[2:0] != want.status) report_mismatch("status", want.status, beat[2:0]);
      if (beat[3] != want.found) report_mismatch("found", want.found, beat[3]);
      if (beat[8:4] != want.match_index)
        report_mismatch("match_index", want.match_index, beat[8:4]);
      if (beat[14:9] != want.length) report_mismatch("length", want.length, beat[14:9]);
      if (beat[M_TDATA_W-1:15] != '0) report_mismatch("padding", 0, beat[M_TDATA_W-1:15]);
    end
  endtask

  // results are checked before the same edge's command is applied
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      list_q.delete();
      outcome_q.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_result(m_axis_tdata_i);
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        outcome_q.push_back(apply_command(s_axis_tdata_i[1:0], s_axis_tdata_i[7:2],
                                          s_axis_tdata_i[39:8]));
        if (list_q.size() > peak_len) peak_len = list_q.size();
      end
    end
    pending = outcome_q.size();
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// top of the positional list testbench: clock, reset, command stimulus and
// result-side stalls; depends on pls_pkg, pls_checker and the block itself
module tb_top;
  import pls_pkg::*;

  localparam int              ITEMS_TOTAL = 1750;
  localparam int              HOLD_OFF    = 120;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int fail_count;
  int pending;
  int checked;
  int peak_len;

  // length tracking used to steer positions toward legal slots, fill mode and the full count
  int                shadow_len = 0;
  logic [DATA_W-1:0] value_pool[$];
  bit                fill_mode  = 1'b1;
  int                n_ins = 0, n_del = 0, n_srch = 0, n_unused = 0, n_full = 0;

  always #5 clk_i = ~clk_i;

  positional_list_insert_delete_search u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  pls_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .peak_len_o      (peak_len)
  );

  // offer one command beat and hold it until accepted; entered and left at a falling edge
  task automatic issue(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] slot,
                       input logic [DATA_W-1:0] val);
    case (op)
      CMD_INSERT: begin
        n_ins++;
        if (shadow_len >= CAPACITY) begin
          n_full++;
        end else if (int'(slot) <= shadow_len) begin
          shadow_len++;
          value_pool.push_back(val);
          if (value_pool.size() > 24) void'(value_pool.pop_front());
        end
      end
      CMD_DELETE: begin
        n_del++;
        if (shadow_len > 0 && slot != '0 && int'(slot) <= shadow_len) shadow_len--;
      end
      CMD_SEARCH: n_srch++;
      default:    n_unused++;
    endcase
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'({val, slot, op});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // sender gap with junk on the data lines
  task automatic idle_gap(input int cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= S_TDATA_W'({$urandom, $urandom});
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  // values: recent inserts for duplicates and hits, corners, or anything
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && value_pool.size() > 0) return value_pool[$urandom_range(0, value_pool.size() - 1)];
    if (r < 6) begin
      case ($urandom_range(0, 4))
        0:       return 32'h0000_0000;
        1:       return 32'h0000_0001;
        2:       return 32'hFFFF_FFFF;
        3:       return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // one random command, mostly legal, drifting between filling and draining
  task automatic random_command();
    int                r;
    logic [CMD_W-1:0]  op;
    logic [POS_W-1:0]  slot;
    logic [DATA_W-1:0] val;
    if (shadow_len >= CAPACITY && $urandom_range(0, 3) == 0) fill_mode = 1'b0;
    if (shadow_len == 0 && $urandom_range(0, 3) == 0) fill_mode = 1'b1;
    if ($urandom_range(0, 199) == 0) fill_mode = !fill_mode;
    r = $urandom_range(0, 99);
    if (fill_mode) op = (r < 55) ? CMD_INSERT : (r < 72) ? CMD_DELETE :
                        (r < 96) ? CMD_SEARCH : CMD_UNUSED;
    else           op = (r < 15) ? CMD_INSERT : (r < 60) ? CMD_DELETE :
                        (r < 96) ? CMD_SEARCH : CMD_UNUSED;
    if ($urandom_range(0, 99) < 85) begin
      if (op == CMD_INSERT) slot = POS_W'($urandom_range(0, shadow_len));
      else if (op == CMD_DELETE) slot = (shadow_len == 0) ? 6'd1 :
                                        POS_W'($urandom_range(1, shadow_len));
      else slot = POS_W'($urandom_range(0, 63));
    end else begin
      slot = POS_W'($urandom_range(0, 63));
    end
    if (op == CMD_SEARCH && value_pool.size() > 0 && $urandom_range(0, 9) < 6)
      val = value_pool[$urandom_range(0, value_pool.size() - 1)];
    else
      val = pick_value();
    issue(op, slot, val);
  endtask

  // stimulus and verdict
  initial begin
    int burst;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed corners: empty list, ends of the list, bad slots, duplicates
    issue(CMD_SEARCH, 6'd0,  32'h0000_0000);   // search on empty list
    issue(CMD_DELETE, 6'd1,  32'h0000_0000);   // delete on empty list
    issue(CMD_INSERT, 6'd1,  32'h0000_000B);   // slot past count on empty list
    issue(CMD_INSERT, 6'd0,  32'h8000_0000);   // first insert into empty list
    issue(CMD_INSERT, 6'd1,  32'h7FFF_FFFF);   // append
    idle_gap(2);
    issue(CMD_INSERT, 6'd0,  32'hFFFF_FFFF);   // insert at head
    issue(CMD_INSERT, 6'd1,  32'h0000_0000);   // insert in the middle
    issue(CMD_INSERT, 6'd5,  32'h0000_0005);   // slot past count
    issue(CMD_INSERT, 6'd63, 32'h1234_5678);   // top slot code
    issue(CMD_INSERT, 6'd4,  32'h7FFF_FFFF);   // duplicate at tail
    issue(CMD_SEARCH, 6'd0,  32'h7FFF_FFFF);   // first of two matches
    idle_gap(1);
    issue(CMD_SEARCH, 6'd9,  32'h1234_5678);   // no match
    issue(CMD_SEARCH, 6'd63, 32'h0000_0000);   // position ignored by search
    issue(CMD_DELETE, 6'd0,  32'h0000_0000);   // delete slot zero
    issue(CMD_DELETE, 6'd6,  32'h0000_0000);   // delete past count
    issue(CMD_DELETE, 6'd63, 32'hFFFF_FFFF);   // top slot code
    issue(CMD_UNUSED, 6'd63, 32'hFFFF_FFFF);   // unused command
    issue(CMD_DELETE, 6'd5,  32'h0000_0000);   // delete tail
    issue(CMD_DELETE, 6'd1,  32'h0000_0000);   // delete head
    issue(CMD_SEARCH, 6'd0,  32'hFFFF_FFFF);   // deleted value is gone
    idle_gap(3);
    issue(CMD_DELETE, 6'd2,  32'h0000_0000);
    issue(CMD_DELETE, 6'd1,  32'h0000_0000);
    issue(CMD_DELETE, 6'd1,  32'h0000_0000);   // list empty again
    issue(CMD_SEARCH, 6'd0,  32'h8000_0000);

    // random bursts of commands with random gaps
    while (n_ins + n_del + n_srch < ITEMS_TOTAL) begin
      burst = $urandom_range(1, 32);
      for (int b = 0; b < burst; b++) random_command();
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
    end
    s_axis_tvalid <= 1'b0;

    // drain, then wait for any stray beat
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("run covered %0d commands: %0d insert, %0d delete, %0d search, %0d unused code",
             n_ins + n_del + n_srch + n_unused, n_ins, n_del, n_srch, n_unused);
    $display("%0d result beats checked, list peaked at %0d of %0d, %0d inserts hit a full list",
             checked, peak_len, CAPACITY, n_full);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side stalls: segments of different ready patterns, two long hold-offs
  initial begin
    int seg;
    int mode;
    int seg_len;
    bit toggle;
    m_axis_tready = 1'b0;
    seg           = 0;
    toggle        = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (seg == 5 || seg == 40) begin
        // hold off long enough for the block to fill and stall its input
        m_axis_tready <= 1'b0;
        for (int hold = 0; hold < HOLD_OFF; hold++) @(negedge clk_i);
      end else begin
        mode    = $urandom_range(0, 3);
        seg_len = $urandom_range(10, 60);
        for (int c = 0; c < seg_len; c++) begin
          toggle = !toggle;
          case (mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= toggle;
          endcase
          @(negedge clk_i);
        end
      end
      seg++;
    end
  end

  // run limit
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
src/pls_pkg.sv
src/pls_cell.sv
src/pls_result.sv
src/positional_list_insert_delete_search.sv
tb/sv/pls_checker.sv
tb/sv/tb_top.sv
